>>> hdl/lac_pkg.sv
// Shared types and constants of the associative LRU cache.
// Used by lac_mem, lac_scan and the top level lru_associative_cache.
package lac_pkg;

  localparam int unsigned WAYS_DEF = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned VAL_W    = 31;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CFGW_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [CFGW_W-1:0] WAYS_RST = 5'd16;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_WAYS = 1'b0;

  // Operation codes of an input transaction.
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // One stored entry; the valid bit is kept in flip-flops outside the memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic start;    // clear the search for a new transaction
    logic chk;      // memory read data is an entry to evaluate
    logic ent_vld;  // valid bit of that entry
  } scan_ctl_t;

  typedef struct packed {
    logic found;    // a valid entry with the requested key was seen
  } scan_sts_t;

endpackage

>>> hdl/lac_mem.sv
// Entry memory of the associative LRU cache: one write port, one read port,
// registered read data. Depends on lac_pkg for the entry type.
module lac_mem
  import lac_pkg::*;
#(
  parameter int unsigned WAYS  = WAYS_DEF,
  parameter int unsigned IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data
);

  entry_t mem_r [WAYS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/lac_scan.sv
// Key match and replacement search over entries streamed from the memory.
// Depends on lac_pkg for the entry and control types.
module lac_scan
  import lac_pkg::*;
#(
  parameter int unsigned WAYS  = WAYS_DEF,
  parameter int unsigned IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_ctl_t        ctl,
  input  logic [KEY_W-1:0] key,
  input  logic [IDX_W-1:0] idx,
  input  entry_t           ent,
  output scan_sts_t        sts,
  output logic [IDX_W-1:0] where_idx,
  output logic [IDX_W-1:0] tgt_idx,
  output logic [VAL_W-1:0] hit_value
);

  logic               found_r;
  logic               free_r;
  logic               have_min_r;
  logic [IDX_W-1:0]   where_r;
  logic [IDX_W-1:0]   tgt_r;
  logic [VAL_W-1:0]   hit_val_r;
  logic [STAMP_W-1:0] min_stamp_r;
  logic               match;
  logic               older;

  assign match = ctl.ent_vld && (ent.key == key);
  assign older = !have_min_r || (ent.stamp < min_stamp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      free_r     <= 1'b0;
      have_min_r <= 1'b0;
    end else if (ctl.start) begin
      found_r    <= 1'b0;
      free_r     <= 1'b0;
      have_min_r <= 1'b0;
    end else if (ctl.chk) begin
      if (match && !found_r) begin
        found_r <= 1'b1;
      end
      // The first free slot ends the victim search; before it, the valid
      // entry with the smallest stamp wins, the lowest index on ties.
      if (!free_r) begin
        if (!ctl.ent_vld) begin
          free_r <= 1'b1;
        end else if (older) begin
          have_min_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.chk) begin
      if (match && !found_r) begin
        where_r   <= idx;
        hit_val_r <= ent.value;
      end
      if (!free_r) begin
        if (!ctl.ent_vld) begin
          tgt_r <= idx;
        end else if (older) begin
          tgt_r       <= idx;
          min_stamp_r <= ent.stamp;
        end
      end
    end
  end

  assign sts.found = found_r;
  assign where_idx = where_r;
  assign tgt_idx   = tgt_r;
  assign hit_value = hit_val_r;

endmodule

>>> hdl/lru_associative_cache.sv
// Top level of the fully associative key/value cache with LRU replacement.
// Depends on lac_pkg, lac_mem and lac_scan.

// A get looks the key up among the first ways_in_use entries and, on a hit,
// returns the stored value and slot and marks the entry as most recently
// used; a put updates a matching entry or else fills the lowest free slot or
// evicts the least recently used one. Entries live in a single-port-read,
// single-port-write memory with registered read data and are read one per
// cycle during the scan. A transaction is accepted, then the first N entries,
// where N is ways_in_use clamped to the range 1 to WAYS, are read and their
// data is checked for a key match and for the replacement victim at once,
// and finally the entry is written back and the result presented. One
// transaction is in flight at a time; its result sits in an
// output register, and the next transaction is taken while that result
// waits, though write-back pauses if the previous result is still stalled.
// Recency is kept as a 32-bit stamp that advances on every put and every
// get hit and wraps around; valid bits are flip-flops cleared at reset, so
// no clearing pass is needed. ways_in_use sits at byte address 0 of the
// APB-style port and should only be changed while the cache is idle;
// entries beyond the active range keep their contents.
module lru_associative_cache
  import lac_pkg::*;
#(
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VAL_W-1:0]   in_value,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [VAL_W-1:0]   out_read_value,
  output logic [SLOT_W-1:0]  out_slot,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned LIM_W = $clog2(WAYS + 1);

  // Configuration register.
  logic [CFGW_W-1:0] cfg_ways_r;
  logic              cfg_wr;
  logic              cfg_sel;

  // Control.
  state_t            state_r, state_nxt;
  logic [LIM_W-1:0]  lim, lim_r;
  logic [LIM_W-1:0]  iss_r, iss_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [STAMP_W-1:0] stamp_r;
  logic [WAYS-1:0]   valid_r;
  logic              in_acc;
  logic              load;
  logic              we;
  logic              last_chk;
  logic              scan_start;

  // Held transaction.
  logic              req_func_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [VAL_W-1:0]  req_val_r;

  // Memory and search.
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_idx;
  entry_t            rd_data;
  entry_t            wr_data;
  scan_ctl_t         ctl;
  scan_sts_t         sts;
  logic [IDX_W-1:0]  where_idx;
  logic [IDX_W-1:0]  tgt_idx;
  logic [VAL_W-1:0]  hit_value;
  logic              get_miss;

  // Result register.
  logic              out_valid_r;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_read_value_r;
  logic [SLOT_W-1:0] out_slot_r;

  // ---------------------------------------------------------------------------
  // Configuration port. The word address picks the register; writes to any
  // other word are dropped and read back as zero.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PADDR_W-1:2] == REG_WAYS);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ways_r <= WAYS_RST;
    end else if (cfg_wr) begin
      cfg_ways_r <= pwdata[CFGW_W-1:0];
    end
  end

  assign prdata = cfg_sel ? DATA_W'(cfg_ways_r) : '0;

  // Number of entries scanned: zero counts as one, and anything above the
  // memory depth is clamped to it.
  always_comb begin
    if (cfg_ways_r == '0) begin
      lim = LIM_W'(1);
    end else if (32'(cfg_ways_r) > 32'(WAYS)) begin
      lim = LIM_W'(WAYS);
    end else begin
      lim = LIM_W'(cfg_ways_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. IDLE takes a transaction and reads entry 0; SCAN keeps one
  // read in flight per cycle while the search checks the data coming back; WRITE
  // stores the touched entry unless a get missed and loads the result register.
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign last_chk = chk_vld_r && ((32'(chk_idx_r) + 32'd1) == 32'(lim_r));
  assign get_miss = (req_func_r == FUNC_GET) && !sts.found;

  always_comb begin
    state_nxt   = state_r;
    iss_nxt     = iss_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    rd_addr     = '0;
    scan_start  = 1'b0;
    load        = 1'b0;
    we          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          scan_start  = 1'b1;
          iss_nxt     = LIM_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = iss_r[IDX_W-1:0];
        if (iss_r < lim_r) begin
          iss_nxt     = iss_r + LIM_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[IDX_W-1:0];
        end
        if (last_chk) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          we        = !get_miss;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      iss_r     <= '0;
      chk_vld_r <= 1'b0;
      stamp_r   <= '0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      iss_r     <= iss_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (we) begin
        stamp_r         <= stamp_r + STAMP_W'(1);
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    if (in_acc) begin
      req_func_r <= in_func;
      req_key_r  <= in_key;
      req_val_r  <= in_value;
      lim_r      <= lim;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry memory and search.
  // ---------------------------------------------------------------------------
  assign ctl = {scan_start, chk_vld_r, valid_r[chk_idx_r]};

  // A hit rewrites the matching entry; a put miss fills the victim. A get
  // keeps the value it found, a put stores the new one.
  assign wr_idx  = sts.found ? where_idx : tgt_idx;
  assign wr_data = {req_key_r, (req_func_r == FUNC_PUT) ? req_val_r : hit_value, stamp_r};

  lac_mem #(
    .WAYS  (WAYS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_idx),
    .wr_data (wr_data)
  );

  lac_scan #(
    .WAYS  (WAYS),
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .key       (req_key_r),
    .idx       (chk_idx_r),
    .ent       (rd_data),
    .sts       (sts),
    .where_idx (where_idx),
    .tgt_idx   (tgt_idx),
    .hit_value (hit_value)
  );

  // ---------------------------------------------------------------------------
  // Result register. A get miss reports slot zero; only a get hit returns
  // a value.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_hit_r        <= sts.found;
      out_read_value_r <= ((req_func_r == FUNC_GET) && sts.found) ? hit_value : '0;
      out_slot_r       <= get_miss ? '0 : SLOT_W'(wr_idx);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_slot       = out_slot_r;

endmodule

>>> tb/lru_cache_checker.sv
`timescale 1ns / 1ps
// Checker for the LRU associative cache: tracks the key/value store, predicts
// every lookup result and compares it with the result channel.
// Depends on lac_pkg for widths, operation codes and register indexes.
module lru_cache_checker
  import lac_pkg::*;
#(
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VAL_W-1:0]   in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic [VAL_W-1:0]   out_read_value,
  input  logic [SLOT_W-1:0]  out_slot,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic               hit;
    logic [VAL_W-1:0]   read_value;
    logic [SLOT_W-1:0]  slot;
  } lookup_t;

  logic [CFGW_W-1:0]  ways_reg;
  logic               entry_valid [WAYS];
  logic [KEY_W-1:0]   entry_key   [WAYS];
  logic [VAL_W-1:0]   entry_value [WAYS];
  logic [STAMP_W-1:0] entry_stamp [WAYS];
  logic [STAMP_W-1:0] stamp_ctr;

  lookup_t expected_lookups [$];
  int      errors;

  function automatic int active_ways();
    if (ways_reg == 0) return 1;
    if (ways_reg > WAYS) return WAYS;
    return int'(ways_reg);
  endfunction

  // Applies one get or put to the tracked store and returns its result.
  function automatic lookup_t cache_access(input logic f, input logic [KEY_W-1:0] k,
                                           input logic [VAL_W-1:0] v);
    lookup_t            r;
    int                 n, i, idx;
    logic               found, done;
    logic [STAMP_W-1:0] oldest;
    r     = '0;
    n     = active_ways();
    found = 1'b0;
    idx   = 0;
    for (i = 0; i < n; i++) begin
      if (!found && entry_valid[i] && entry_key[i] == k) begin
        found = 1'b1;
        idx   = i;
      end
    end
    if (found) begin
      r.hit  = 1'b1;
      r.slot = idx[SLOT_W-1:0];
      if (f == FUNC_GET) r.read_value = entry_value[idx];
      else entry_value[idx] = v;
      entry_stamp[idx] = stamp_ctr;
      stamp_ctr        = stamp_ctr + 1;
    end else if (f == FUNC_PUT) begin
      // First free slot wins; otherwise the oldest stamp, lowest index on ties.
      oldest = entry_stamp[0];
      done   = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!done) begin
          if (!entry_valid[i]) begin
            idx  = i;
            done = 1'b1;
          end else if (entry_stamp[i] < oldest) begin
            oldest = entry_stamp[i];
            idx    = i;
          end
        end
      end
      entry_key[idx]   = k;
      entry_value[idx] = v;
      entry_valid[idx] = 1'b1;
      entry_stamp[idx] = stamp_ctr;
      stamp_ctr        = stamp_ctr + 1;
      r.slot           = idx[SLOT_W-1:0];
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] want,
                        input logic [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    lookup_t want;
    int      i;
    if (!rst_n) begin
      ways_reg  = WAYS_RST;
      stamp_ctr = '0;
      for (i = 0; i < WAYS; i++) begin
        entry_valid[i] = 1'b0;
        entry_key[i]   = '0;
        entry_value[i] = '0;
        entry_stamp[i] = '0;
      end
      expected_lookups.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_WAYS) begin
        if (pwrite) ways_reg = pwdata[CFGW_W-1:0];
        else if (prdata[CFGW_W-1:0] != ways_reg)
          report("ways_in_use readback", DATA_W'(ways_reg), DATA_W'(prdata[CFGW_W-1:0]));
      end
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: result with none expected, actual hit %0d value %0h slot %0d",
                   $time, out_hit, out_read_value, out_slot);
          errors++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_hit != want.hit) report("hit", DATA_W'(want.hit), DATA_W'(out_hit));
          if (out_read_value != want.read_value)
            report("read_value", DATA_W'(want.read_value), DATA_W'(out_read_value));
          if (out_slot != want.slot) report("slot", DATA_W'(want.slot), DATA_W'(out_slot));
        end
      end
      if (in_valid && !in_stall)
        expected_lookups.push_back(cache_access(in_func, in_key, in_value));
    end
    pending    <= expected_lookups.size();
    fail_count <= errors;
  end

endmodule

>>> tb/tb_lru_associative_cache.sv
`timescale 1ns / 1ps
// Top of the LRU associative cache testbench: clock, reset, stimulus, verdict.
// Depends on lac_pkg, lru_associative_cache and lru_cache_checker.
module tb_lru_associative_cache;
  import lac_pkg::*;

  // The word index above the only register; writes there must be ignored.
  localparam logic REG_SPARE = 1'b1;
  localparam int   POOL      = 24;
  localparam int   PHASES    = 10;
  localparam int   PHASE_LEN = 158;
  localparam int   HOLD_LEN  = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_func;
  logic [KEY_W-1:0]   in_key;
  logic [VAL_W-1:0]   in_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic [VAL_W-1:0]   out_read_value;
  logic [SLOT_W-1:0]  out_slot;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               hold_req;
  int                 fail_count;
  int                 pending;

  // Keys that random transactions mostly draw from, so hits, updates and
  // evictions are frequent. A few entries change at every phase.
  logic [KEY_W-1:0]   key_pool [POOL];

  always #10 clk = ~clk;

  lru_associative_cache dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_key, .in_value,
    .out_valid, .out_stall, .out_hit, .out_read_value, .out_slot,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lru_cache_checker chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_key, .in_value,
    .out_valid, .out_stall, .out_hit, .out_read_value, .out_slot,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending
  );

  // Offers one transaction and returns at the edge where it is taken. The
  // valid stays high so the caller can either follow up or open a gap.
  task automatic offer(input logic f, input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    in_valid <= 1'b1;
    in_func  <= f;
    in_key   <= k;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // One APB access: setup cycle, then access cycle until pready. A spare
  // cycle at the end keeps back-to-back accesses from touching psel twice
  // in the same step.
  task automatic cfg_access(input logic wr, input logic idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Every transaction yields a result, so once nothing is pending the cache
  // is idle; an extra wait at the end covers the write-back.
  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // A random phase: set ways_in_use (upper bits of the word are junk and
  // must be masked), read it back, then stream bursts of gets and puts.
  task automatic run_phase(input logic [CFGW_W-1:0] ways, input int items);
    logic [DATA_W-1:0] word;
    int                n, used, burst, gap, i;
    logic              f;
    logic [KEY_W-1:0]  k;
    wait_idle();
    word       = $urandom;
    word[4:0]  = ways;
    cfg_access(1'b1, REG_WAYS, word);
    cfg_access(1'b0, REG_WAYS, '0);
    n = (ways == 0) ? 1 : (ways > WAYS_DEF) ? WAYS_DEF : int'(ways);
    used = n + $urandom_range(1, 4);
    if (used > POOL) used = POOL;
    for (i = 0; i < 4; i++)
      key_pool[$urandom_range(0, POOL - 1)] = KEY_W'($urandom_range(0, 16'hFFFF));
    burst = 0;
    for (i = 0; i < items; i++) begin
      if (burst == 0) begin
        // Roughly a third of the bursts follow on with no gap at all.
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      f = ($urandom_range(0, 99) < 45) ? FUNC_PUT : FUNC_GET;
      k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(0, 16'hFFFF))
                                      : key_pool[$urandom_range(0, used - 1)];
      offer(f, k, VAL_W'($urandom_range(0, 32'h7FFF_FFFF)));
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // Result side: stretches of random stall density, including none, plus one
  // long hold-off once requested, started while the sender is offering so the
  // cache backs up into its input.
  initial begin
    int unsigned span, pct, c;
    bit          held;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (hold_req && !held && in_valid) begin
        held      = 1'b1;
        out_stall <= 1'b1;
        for (c = 0; c < HOLD_LEN; c++) @(posedge clk);
      end else begin
        span = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 25;
          default: pct = 60;
        endcase
        for (c = 0; c < span; c++) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  // The timeout leaves several times the slowest correct run, stalls
  // included.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [CFGW_W-1:0] settings [PHASES];
    int                p;
    settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd2, 5'd17, 5'd8, 5'd12};
    for (p = 0; p < POOL; p++) key_pool[p] = KEY_W'($urandom_range(0, 16'hFFFF));
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_func  <= FUNC_GET;
    in_key   <= '0;
    in_value <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    hold_req <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lookup in an empty cache, extreme keys and values, a hit, an
    // update of an existing entry, then a plain miss.
    offer(FUNC_GET, 16'h0000, '0);
    offer(FUNC_PUT, 16'h0000, '0);
    offer(FUNC_PUT, 16'hFFFF, 31'h7FFF_FFFF);
    offer(FUNC_GET, 16'hFFFF, '0);
    offer(FUNC_GET, 16'h0000, 31'h5555_5555);
    offer(FUNC_PUT, 16'h0000, 31'h7FFF_FFFF);
    offer(FUNC_GET, 16'h1234, '0);
    in_valid <= 1'b0;
    wait_idle();

    // Two ways: both slots are taken, so new keys evict the least recently
    // used one. A write to the unused register index must change nothing.
    cfg_access(1'b1, REG_WAYS, 32'd2);
    cfg_access(1'b1, REG_SPARE, 32'hFFFF_FFFF);
    cfg_access(1'b0, REG_WAYS, '0);
    offer(FUNC_PUT, 16'h0001, 31'd1);
    offer(FUNC_GET, 16'hFFFF, '0);
    offer(FUNC_GET, 16'h0000, '0);
    offer(FUNC_PUT, 16'h0002, 31'd2);
    in_valid <= 1'b0;
    wait_idle();

    // A zero setting scans one way, so slot 1 falls out of range.
    cfg_access(1'b1, REG_WAYS, 32'd0);
    offer(FUNC_GET, 16'h0002, '0);
    offer(FUNC_PUT, 16'h0003, 31'd3);
    offer(FUNC_GET, 16'h0003, '0);
    in_valid <= 1'b0;
    wait_idle();

    // An oversized setting saturates; the out-of-range entry is back.
    cfg_access(1'b1, REG_WAYS, 32'd31);
    offer(FUNC_GET, 16'h0002, '0);
    offer(FUNC_PUT, 16'h0004, 31'd4);
    offer(FUNC_GET, 16'hFFFF, '0);
    offer(FUNC_PUT, 16'hFFFF, 31'd5);
    in_valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      if (p == 4) hold_req <= 1'b1;
      run_phase(settings[p], PHASE_LEN);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
